/* src/adagrad_parameter_update_top_assert.svh */
// ----------------------------------------------------------------------------
// AdaGrad update assertion macros
// Shared assertion forms for the checker of the AdaGrad update block.
// ----------------------------------------------------------------------------
`ifndef ADAGRAD_PARAMETER_UPDATE_TOP_ASSERT_SVH
`define ADAGRAD_PARAMETER_UPDATE_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define ADU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ADU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/adu_pkg.sv */
// ----------------------------------------------------------------------------
// AdaGrad update package
// Widths, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
package adu_pkg;

    localparam int IW    = 12;
    localparam int GW    = 32;
    localparam int CW    = 48;
    localparam int LRW   = 24;
    localparam int EPSW  = 32;
    localparam int SQW   = 40;
    localparam int SUMW  = 49;
    localparam int PRODW = 56;
    localparam int RADW  = 64;
    localparam int ROOTW = 32;
    localparam int REMW  = 36;
    localparam int DW    = 37;
    localparam int DREMW = 38;
    localparam int QW    = 32;
    localparam int DATAW = 32;
    localparam int PAW   = 3;

    localparam int FIFO_DEPTH = 128;
    localparam int FAW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = $clog2(FIFO_DEPTH + 1);

    localparam logic [0:0] REG_LR  = 1'b0;
    localparam logic [0:0] REG_EPS = 1'b1;

    localparam logic [LRW-1:0]  LR_RESET  = 24'd16777;
    localparam logic [EPSW-1:0] EPS_RESET = 32'd1;

    localparam logic [CW-1:0] CACHE_MAX     = {CW{1'b1}};
    localparam logic [GW-1:0] DELTA_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [GW-1:0] DELTA_NEG_MAX = 32'h8000_0000;

    typedef struct packed {
        logic [IW-1:0]    idx;
        logic             neg;
        logic             zero;
        logic [PRODW-1:0] prod;
    } t_side;

    typedef struct packed {
        logic [IW-1:0] idx;
        logic          neg;
        logic          zero;
        logic          sat;
    } t_dpay;

endpackage

/* src/adu_cache.sv */
// ----------------------------------------------------------------------------
// AdaGrad cache read-modify-write
// Holds the squared-gradient cache in a synchronous memory, adds each item's
// squared gradient with forwarding, and clears the memory after reset.
// ----------------------------------------------------------------------------
module adu_cache #(
    parameter int NUM_PARAMS = 4096,
    parameter int AW         = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [adu_pkg::IW-1:0]        i_idx,
    input  logic [adu_pkg::GW-1:0]        i_gradient,
    input  logic [adu_pkg::LRW-1:0]       i_lr,
    input  logic [adu_pkg::EPSW-1:0]      i_eps,
    output logic                          o_busy,
    output logic                          o_valid,
    output adu_pkg::t_side                o_side,
    output logic [adu_pkg::RADW-1:0]      o_rad
);
    import adu_pkg::*;

    logic [CW-1:0]   r_mem [NUM_PARAMS];
    logic [CW-1:0]   r_rdata;
    logic            r_clr_busy;
    logic [AW-1:0]   r_clr_addr;

    logic            w_neg;
    logic [GW-1:0]   w_magg;
    logic [SQW-1:0]  w_sq;
    logic            w_inr;
    logic [AW-1:0]   w_addr;
    logic [2*GW-1:0] w_sq_full;

    logic            r_a_valid;
    logic [IW-1:0]   r_a_idx;
    logic            r_a_neg;
    logic [GW-1:0]   r_a_magg;
    logic [SQW-1:0]  r_a_sq;
    logic            r_a_inr;
    logic [AW-1:0]   r_a_addr;
    logic            r_a_hit;

    logic [CW-1:0]   w_old;
    logic [SUMW-1:0] w_sum;
    logic [CW-1:0]   n_cache;

    logic            r_b_valid;
    logic [CW-1:0]   r_b_cache;
    t_side           r_b_side;
    logic [SUMW-1:0] w_s;

    assign w_neg     = i_gradient[GW-1];
    assign w_magg    = w_neg ? (~i_gradient + 1'b1) : i_gradient;
    assign w_sq_full = {{GW{1'b0}}, w_magg} * {{GW{1'b0}}, w_magg};
    assign w_sq      = w_sq_full[SQW+23:24];
    assign w_inr     = 32'(i_idx) < 32'(NUM_PARAMS);
    assign w_addr    = AW'(i_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(NUM_PARAMS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_a_valid && r_a_inr) begin
            r_mem[r_a_addr] <= n_cache;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_hit   <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_a_hit   <= r_a_valid && r_a_inr && w_inr && (r_a_addr == w_addr);
        end
        r_a_idx  <= i_idx;
        r_a_neg  <= w_neg;
        r_a_magg <= w_magg;
        r_a_sq   <= w_sq;
        r_a_inr  <= w_inr;
        r_a_addr <= w_addr;
    end

    always_comb begin
        if (!r_a_inr) begin
            w_old = '0;
        end else if (r_a_hit) begin
            w_old = r_b_cache;
        end else begin
            w_old = r_rdata;
        end
        w_sum   = SUMW'(w_old) + SUMW'(r_a_sq);
        n_cache = w_sum[SUMW-1] ? CACHE_MAX : w_sum[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_cache     <= n_cache;
        r_b_side.idx  <= r_a_idx;
        r_b_side.neg  <= r_a_neg;
        r_b_side.zero <= (r_a_magg == '0);
        r_b_side.prod <= PRODW'(i_lr) * PRODW'(r_a_magg);
    end

    assign w_s     = SUMW'(r_b_cache) + SUMW'(i_eps);
    assign o_rad   = {1'b0, w_s, 14'b0};
    assign o_valid = r_b_valid;
    assign o_side  = r_b_side;
    assign o_busy  = r_clr_busy;

endmodule

/* src/adu_sqrt.sv */
// ----------------------------------------------------------------------------
// AdaGrad square root pipeline
// Integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module adu_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  adu_pkg::t_side              i_side,
    input  logic [adu_pkg::RADW-1:0]    i_rad,
    output logic                        o_valid,
    output adu_pkg::t_side              o_side,
    output logic [adu_pkg::ROOTW-1:0]   o_root
);
    import adu_pkg::*;

    logic             r_valid [1:ROOTW];
    t_side            r_side  [1:ROOTW];
    logic [RADW-1:0]  r_rad   [1:ROOTW];
    logic [REMW-1:0]  r_rem   [1:ROOTW];
    logic [ROOTW-1:0] r_root  [1:ROOTW];

    logic             w_valid [0:ROOTW-1];
    t_side            w_side  [0:ROOTW-1];
    logic [RADW-1:0]  w_rad   [0:ROOTW-1];
    logic [REMW-1:0]  w_rem   [0:ROOTW-1];
    logic [ROOTW-1:0] w_root  [0:ROOTW-1];

    for (genvar k = 0; k < ROOTW; k++) begin : g_stage
        logic [REMW-1:0] w_t;
        logic [REMW-1:0] w_trial;
        logic            w_ge;

        if (k == 0) begin : g_first
            assign w_valid[k] = i_valid;
            assign w_side[k]  = i_side;
            assign w_rad[k]   = i_rad;
            assign w_rem[k]   = '0;
            assign w_root[k]  = '0;
        end else begin : g_rest
            assign w_valid[k] = r_valid[k];
            assign w_side[k]  = r_side[k];
            assign w_rad[k]   = r_rad[k];
            assign w_rem[k]   = r_rem[k];
            assign w_root[k]  = r_root[k];
        end

        assign w_t     = {w_rem[k][REMW-3:0], w_rad[k][RADW-1 -: 2]};
        assign w_trial = REMW'({w_root[k], 2'b01});
        assign w_ge    = (w_t >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else begin
                r_valid[k+1] <= w_valid[k];
            end
            r_side[k+1] <= w_side[k];
            r_rad[k+1]  <= w_rad[k] << 2;
            r_rem[k+1]  <= w_ge ? (w_t - w_trial) : w_t;
            r_root[k+1] <= {w_root[k][ROOTW-2:0], w_ge};
        end
    end

    assign o_valid = r_valid[ROOTW];
    assign o_side  = r_side[ROOTW];
    assign o_root  = r_root[ROOTW];

endmodule

/* src/adu_div.sv */
// ----------------------------------------------------------------------------
// AdaGrad divide and saturate pipeline
// Restoring division of lr*|g| by the scaled root, one quotient
// bit per stage, then sign and saturation of the delta.
// ----------------------------------------------------------------------------
module adu_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  adu_pkg::t_side              i_side,
    input  logic [adu_pkg::ROOTW-1:0]   i_root,
    output logic                        o_valid,
    output logic [adu_pkg::IW-1:0]      o_idx,
    output logic [adu_pkg::GW-1:0]      o_delta
);
    import adu_pkg::*;

    logic             r_valid [0:QW];
    t_dpay            r_pay   [0:QW];
    logic [DW-1:0]    r_d     [0:QW];
    logic [DREMW-1:0] r_rem   [0:QW];
    logic [QW-1:0]    r_low   [0:QW];
    logic [QW-1:0]    r_q     [0:QW];

    logic [DW-1:0]    w_d;
    logic             w_ovf;

    logic             r_o_valid;
    logic [IW-1:0]    r_o_idx;
    logic [GW-1:0]    r_o_delta;
    logic [GW-1:0]    n_delta;
    t_dpay            w_fpay;
    logic [QW-1:0]    w_fq;

    assign w_d   = {i_root, 5'b0};
    assign w_ovf = DW'(i_side.prod[PRODW-1:QW]) >= w_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
        r_pay[0].idx  <= i_side.idx;
        r_pay[0].neg  <= i_side.neg;
        r_pay[0].zero <= i_side.zero;
        r_pay[0].sat  <= w_ovf || (i_root == '0);
        r_d[0]        <= w_d;
        r_rem[0]      <= DREMW'(i_side.prod[PRODW-1:QW]);
        r_low[0]      <= i_side.prod[QW-1:0];
        r_q[0]        <= '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DREMW-1:0] w_t;
        logic             w_ge;

        assign w_t  = {r_rem[k][DREMW-2:0], r_low[k][QW-1]};
        assign w_ge = (w_t >= DREMW'(r_d[k]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else begin
                r_valid[k+1] <= r_valid[k];
            end
            r_pay[k+1] <= r_pay[k];
            r_d[k+1]   <= r_d[k];
            r_rem[k+1] <= w_ge ? (w_t - DREMW'(r_d[k])) : w_t;
            r_low[k+1] <= r_low[k] << 1;
            r_q[k+1]   <= {r_q[k][QW-2:0], w_ge};
        end
    end

    assign w_fpay = r_pay[QW];
    assign w_fq   = r_q[QW];

    always_comb begin
        if (w_fpay.zero) begin
            n_delta = '0;
        end else if (w_fpay.sat) begin
            n_delta = w_fpay.neg ? DELTA_POS_MAX : DELTA_NEG_MAX;
        end else if (w_fpay.neg) begin
            n_delta = (w_fq > DELTA_POS_MAX) ? DELTA_POS_MAX : w_fq;
        end else begin
            n_delta = (w_fq > DELTA_NEG_MAX) ? DELTA_NEG_MAX : (~w_fq + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_valid[QW];
        end
        r_o_idx   <= w_fpay.idx;
        r_o_delta <= n_delta;
    end

    assign o_valid = r_o_valid;
    assign o_idx   = r_o_idx;
    assign o_delta = r_o_delta;

endmodule

/* src/adu_fifo.sv */
// ----------------------------------------------------------------------------
// AdaGrad output queue
// Result memory with a registered read port that doubles as the output
// register, so the pipeline keeps running while results wait.
// ----------------------------------------------------------------------------
module adu_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr,
    input  logic [adu_pkg::IW-1:0]  i_idx,
    input  logic [adu_pkg::GW-1:0]  i_delta,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic [adu_pkg::IW-1:0]  o_idx,
    output logic [adu_pkg::GW-1:0]  o_delta
);
    import adu_pkg::*;

    logic [IW+GW-1:0] r_mem [FIFO_DEPTH];
    logic [IW+GW-1:0] r_q;
    logic [FAW-1:0]   r_wptr;
    logic [FAW-1:0]   r_rptr;
    logic [FCW-1:0]   r_cnt;
    logic             r_valid;
    logic             w_rd;
    logic             w_pop;

    assign w_pop = r_valid && !i_stall;
    assign w_rd  = (r_cnt != '0) && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= {i_idx, i_delta};
        end
        if (w_rd) begin
            r_q <= r_mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + FCW'(i_wr) - FCW'(w_rd);
            if (w_rd) begin
                r_valid <= 1'b1;
            end else if (w_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_idx   = r_q[IW+GW-1:GW];
    assign o_delta = r_q[GW-1:0];

endmodule

/* src/adagrad_parameter_update_top.sv */
// ----------------------------------------------------------------------------
// AdaGrad parameter update
// Per-parameter AdaGrad step: cache += g*g, delta = -lr*g/sqrt(cache+eps).
//
//   Channel  Signals                                     Direction
//   input    i_valid, o_stall, i_param_index, i_gradient  in
//   output   o_valid, i_stall, o_param_index_out,         out
//            o_weight_delta
//   config   psel, penable, pwrite, paddr, pwdata,        in / out
//            prdata, pready
//
// One item is taken per cycle while o_stall is low; the cache memory port
// reads every cycle and writes back each in-range item, with forwarding
// between neighboring items. The delay from acceptance to a valid result
// is set mostly by the 32-stage root and 32-stage divider.
// After reset the cache is cleared one entry a cycle, with o_stall high.
// A 128-entry result queue absorbs output stalls; input stalls only once
// 128 items are in flight.
// ----------------------------------------------------------------------------
module adagrad_parameter_update_top #(
    parameter int NUM_PARAMS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [adu_pkg::IW-1:0]        i_param_index,
    input  logic [adu_pkg::GW-1:0]        i_gradient,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [adu_pkg::IW-1:0]        o_param_index_out,
    output logic [adu_pkg::GW-1:0]        o_weight_delta,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adu_pkg::PAW-1:0]       paddr,
    input  logic [adu_pkg::DATAW-1:0]     pwdata,
    output logic [adu_pkg::DATAW-1:0]     prdata,
    output logic                          pready
);
    import adu_pkg::*;

    localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

    logic [LRW-1:0]   r_lr;
    logic [EPSW-1:0]  r_eps;
    logic [FCW-1:0]   r_occ;

    logic             w_accept;
    logic             w_pop;
    logic             w_busy;

    logic             w_c_valid;
    t_side            w_c_side;
    logic [RADW-1:0]  w_c_rad;
    logic             w_s_valid;
    t_side            w_s_side;
    logic [ROOTW-1:0] w_s_root;
    logic             w_d_valid;
    logic [IW-1:0]    w_d_idx;
    logic [GW-1:0]    w_d_delta;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= LR_RESET;
            r_eps <= EPS_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_LR:  r_lr  <= pwdata[LRW-1:0];
                REG_EPS: r_eps <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LR:  prdata = DATAW'(r_lr);
            REG_EPS: prdata = r_eps;
            default: prdata = '0;
        endcase
    end

    assign o_stall  = w_busy || (r_occ == FCW'(FIFO_DEPTH));
    assign w_accept = i_valid && !o_stall;
    assign w_pop    = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= r_occ + FCW'(w_accept) - FCW'(w_pop);
        end
    end

    adu_cache #(
        .NUM_PARAMS (NUM_PARAMS),
        .AW         (AW)
    ) u_cache (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_idx      (i_param_index),
        .i_gradient (i_gradient),
        .i_lr       (r_lr),
        .i_eps      (r_eps),
        .o_busy     (w_busy),
        .o_valid    (w_c_valid),
        .o_side     (w_c_side),
        .o_rad      (w_c_rad)
    );

    adu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_valid),
        .i_side  (w_c_side),
        .i_rad   (w_c_rad),
        .o_valid (w_s_valid),
        .o_side  (w_s_side),
        .o_root  (w_s_root)
    );

    adu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s_valid),
        .i_side  (w_s_side),
        .i_root  (w_s_root),
        .o_valid (w_d_valid),
        .o_idx   (w_d_idx),
        .o_delta (w_d_delta)
    );

    adu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_d_valid),
        .i_idx   (w_d_idx),
        .i_delta (w_d_delta),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_idx   (o_param_index_out),
        .o_delta (o_weight_delta)
    );

endmodule

/* src/adu_checker.sv */
// ----------------------------------------------------------------------------
// AdaGrad update port checker
// Watches the top-level ports for output handshake and reset behavior.
// ----------------------------------------------------------------------------
`include "adagrad_parameter_update_top_assert.svh"

module adu_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [adu_pkg::IW-1:0]        o_param_index_out,
    input logic [adu_pkg::GW-1:0]        o_weight_delta
);

    `ADU_ASSERT(a_out_valid_holds,
        o_valid && i_stall |=> o_valid,
        "Output item dropped while stalled.")
    `ADU_ASSERT(a_out_data_holds,
        o_valid && i_stall |=> $stable(o_weight_delta) && $stable(o_param_index_out),
        "Stalled output item changed.")
    `ADU_ASSERT_ALWAYS(a_clear_stalls,
        !i_rst_n |=> o_stall,
        "Input not stalled at start of cache clear.")
    `ADU_ASSERT_ALWAYS(a_reset_empty,
        !i_rst_n |=> !o_valid,
        "Output valid right after reset.")

endmodule

bind adagrad_parameter_update_top adu_checker u_adu_checker (.*);
